/* hw/rtl/bbpm_pkg.sv */
// Shared types and constants for the bipartite buffer pointer manager.
// No dependencies; used by bbpm_core and the top level.
package bbpm_pkg;

    localparam int unsigned POS_W     = 17;
    localparam int unsigned MAX_BYTES = 65536;

    localparam logic [POS_W-1:0] MAX_SIZE = POS_W'(MAX_BYTES);

    // Configuration register indexes
    typedef enum logic {
        CFG_BUFFER_SIZE = 1'b0,
        CFG_SYNC_MODE   = 1'b1
    } t_cfg_idx;

    // Request function codes
    typedef enum logic [1:0] {
        FN_RESERVE = 2'd0,
        FN_COMMIT  = 2'd1,
        FN_READ    = 2'd2,
        FN_CONSUME = 2'd3
    } t_func;

    typedef struct packed {
        logic [POS_W-1:0] rd;
        logic [POS_W-1:0] wr;
        logic [POS_W-1:0] mark;
    } t_ptrs;

    typedef struct packed {
        t_func            func;
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] start;
        logic             wrapped;
        logic [POS_W-1:0] prior;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] start;
        logic             wrapped;
        logic [POS_W-1:0] prior;
        logic [POS_W-1:0] avail;
    } t_result;

endpackage

/* hw/rtl/bbpm_core.sv */
// Combinational decision logic: one request against the current pointers.
// Depends on bbpm_pkg for the pointer, request and result types.
module bbpm_core
    import bbpm_pkg::*;
(
    input  t_ptrs            i_ptrs,
    input  logic [POS_W-1:0] i_buf_size,
    input  logic             i_sync_mode,
    input  t_req             i_req,
    output t_ptrs            o_ptrs,
    output t_result          o_result
);

    logic             rewind;
    logic [POS_W-1:0] rd_eff;
    logic [POS_W-1:0] wr_eff;
    logic [POS_W-1:0] room_tail;
    logic             fit_tail;
    logic [POS_W-1:0] end_pos;

    always_comb begin
        // Reserve: optional rewind of an empty buffer, then tail / head fit
        rewind    = i_sync_mode && (i_ptrs.rd == i_ptrs.wr);
        rd_eff    = rewind ? '0 : i_ptrs.rd;
        wr_eff    = rewind ? '0 : i_ptrs.wr;
        room_tail = i_buf_size - wr_eff;
        fit_tail  = (wr_eff <= i_buf_size) && (room_tail >= i_req.len);
        // Commit and consume share the end-of-region sum, kept modulo 2^17
        end_pos   = i_req.start + i_req.len;

        o_ptrs   = i_ptrs;
        o_result = '0;

        unique case (i_req.func)
            FN_RESERVE: begin
                o_ptrs.rd = rd_eff;
                o_ptrs.wr = wr_eff;
                if (wr_eff >= rd_eff) begin
                    if (fit_tail) begin
                        o_result.ok    = 1'b1;
                        o_result.start = wr_eff;
                        o_result.prior = wr_eff;
                    end else if (rd_eff > i_req.len) begin
                        o_result.ok      = 1'b1;
                        o_result.wrapped = 1'b1;
                        o_result.prior   = wr_eff;
                    end
                end else if ((rd_eff - wr_eff) > i_req.len) begin
                    o_result.ok    = 1'b1;
                    o_result.start = wr_eff;
                    o_result.prior = wr_eff;
                end
            end
            FN_COMMIT: begin
                o_result.ok = 1'b1;
                if (i_req.len != '0) begin
                    if (i_req.wrapped) begin
                        o_ptrs.mark = i_req.prior;
                    end
                    o_ptrs.wr = end_pos;
                end
            end
            FN_READ: begin
                // Readable run: up to write, up to the mark, or wrapped to zero
                if (i_ptrs.wr >= i_ptrs.rd) begin
                    o_result.avail = i_ptrs.wr - i_ptrs.rd;
                    o_result.start = i_ptrs.rd;
                end else if (i_ptrs.rd == i_ptrs.mark) begin
                    o_result.avail = i_ptrs.wr;
                    o_result.start = '0;
                end else if (i_ptrs.mark > i_ptrs.rd) begin
                    o_result.avail = i_ptrs.mark - i_ptrs.rd;
                    o_result.start = i_ptrs.rd;
                end
                o_result.ok = (o_result.avail != '0);
                if (!o_result.ok) begin
                    o_result.start = '0;
                end
            end
            FN_CONSUME: begin
                o_result.ok = 1'b1;
                o_ptrs.rd   = end_pos;
            end
            default: begin
                o_ptrs   = i_ptrs;
                o_result = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/bipartite_buffer_pointer_manager.sv */
// Top level of the bipartite buffer pointer manager: pointer and config
// registers, result register with skid stage. Uses bbpm_pkg and bbpm_core.
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_func, i_length, i_region_start,
//                                            i_region_wrapped, i_prior_write
//  result    out        o_valid / i_stall    o_ok, o_out_start, o_out_wrapped,
//                                            o_out_prior_write, o_avail_len
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request per cycle while o_stall is low; the result is registered,
// set by the single compare/subtract pass between the pointer registers.
// Reset (synchronous): size 65536, sync mode on, rd/wr at zero, mark 65536.
// A two-entry output (result register plus skid) keeps requests flowing
// while a result is stalled; o_stall rises only when both entries are full.
module bipartite_buffer_pointer_manager
    import bbpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_func,
    input  logic [POS_W-1:0] i_length,
    input  logic [POS_W-1:0] i_region_start,
    input  logic             i_region_wrapped,
    input  logic [POS_W-1:0] i_prior_write,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_ok,
    output logic [POS_W-1:0] o_out_start,
    output logic             o_out_wrapped,
    output logic [POS_W-1:0] o_out_prior_write,
    output logic [POS_W-1:0] o_avail_len,
    // configuration port
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [POS_W-1:0] i_cfg_data
);

    logic [POS_W-1:0] r_buf_size;
    logic             r_sync_mode;
    t_ptrs            r_ptrs;
    t_ptrs            n_ptrs;
    logic             r_out_valid;
    t_result          r_out;
    logic             r_skid_valid;
    t_result          r_skid;

    t_req             req;
    t_result          result;
    logic             accept;
    logic             out_fire;
    logic [POS_W-1:0] cfg_size;

    assign req.func    = t_func'(i_func);
    assign req.len     = i_length;
    assign req.start   = i_region_start;
    assign req.wrapped = i_region_wrapped;
    assign req.prior   = i_prior_write;

    assign o_stall  = r_skid_valid;
    assign accept   = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;
    assign cfg_size = (i_cfg_data > MAX_SIZE) ? MAX_SIZE : i_cfg_data;

    bbpm_core u_core (
        .i_ptrs      (r_ptrs),
        .i_buf_size  (r_buf_size),
        .i_sync_mode (r_sync_mode),
        .i_req       (req),
        .o_ptrs      (n_ptrs),
        .o_result    (result)
    );

    // Config and pointer state; a size write reinitializes the pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size  <= MAX_SIZE;
            r_sync_mode <= 1'b1;
            r_ptrs.rd   <= '0;
            r_ptrs.wr   <= '0;
            r_ptrs.mark <= MAX_SIZE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BUFFER_SIZE: begin
                    r_buf_size  <= cfg_size;
                    r_ptrs.rd   <= '0;
                    r_ptrs.wr   <= '0;
                    r_ptrs.mark <= cfg_size;
                end
                CFG_SYNC_MODE: begin
                    r_sync_mode <= i_cfg_data[0];
                end
                default: begin
                    r_sync_mode <= r_sync_mode;
                end
            endcase
        end else if (accept) begin
            r_ptrs <= n_ptrs;
        end
    end

    // Output valid flags: result register fed directly or from the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_ok              = r_out.ok;
    assign o_out_start       = r_out.start;
    assign o_out_wrapped     = r_out.wrapped;
    assign o_out_prior_write = r_out.prior;
    assign o_avail_len       = r_out.avail;

`ifndef NO_ASSERTIONS
    // skid entry only ever holds a result behind a waiting one
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while result register is empty");

    // a request taken while the output is stalled lands in the skid
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("request accepted under stall was not kept in skid");

    // a size write clears both positions and sets the mark to the size
    a_size_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_BUFFER_SIZE))
        |=> (r_ptrs.rd == '0) && (r_ptrs.wr == '0) && (r_ptrs.mark == r_buf_size))
        else $error("size write did not reinitialize the pointers");

    // buffer size stays saturated
    a_size_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_we) |-> (r_buf_size <= MAX_SIZE))
        else $error("buffer size above maximum");
`endif

endmodule
